FILE: hw/rtl/kwcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_pkg
// Types, constants and shared arithmetic helpers of the kinematic wave solver.
// ----------------------------------------------------------------------------
package kwcs_pkg;

  localparam int CELL_INDEX_BITS = 16;
  localparam int ROOT_STEPS      = 22;
  localparam int DIV_STEPS       = 64;
  localparam int NORM_MAX        = 16;

  localparam logic [63:0] VMAX        = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FIVE_THIRDS = 64'd27962027;

  localparam logic [31:0] DT_SECS_RST    = 32'd3932160;
  localparam logic [7:0]  ITER_LIMIT_RST = 8'd100;
  localparam logic [31:0] STEP_TOL_RST   = 32'd1678;

  localparam logic [1:0] REG_DT_SECS    = 2'd0;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd1;
  localparam logic [1:0] REG_STEP_TOL   = 2'd2;

  typedef struct packed {
    logic [CELL_INDEX_BITS-1:0] cell_index;
    logic [31:0]                flow_depth;
    logic [31:0]                upslope_discharge;
    logic [31:0]                manning_alpha;
    logic [31:0]                flow_length;
  } in_item_t;

  typedef struct packed {
    logic [CELL_INDEX_BITS-1:0] cell_tag;
    logic [31:0]                kept_depth;
    logic [31:0]                routed_depth;
    logic [7:0]                 iterations_used;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_PF_CBRT,
    S_PF_C2,
    S_PF_Q53,
    S_CDIS,
    S_A53,
    S_QINIT,
    S_LOOP,
    S_IT_CBRT,
    S_IT_C2,
    S_IT_Q53,
    S_IT_M1,
    S_IT_M2,
    S_IT_M3,
    S_IT_DIV,
    S_IT_UPD,
    S_POST,
    S_POST_MUL,
    S_POST_DIV
  } state_t;

  typedef enum logic [2:0] {
    MS_CC,
    MS_FC2,
    MS_AQ53,
    MS_AK,
    MS_QC2,
    MS_DTQ,
    MS_A53C2,
    MS_QDT
  } mul_sel_t;

  typedef enum logic {
    DS_STEP,
    DS_ROUTE
  } div_sel_t;

  typedef enum logic {
    CS_F,
    CS_Q
  } cbrt_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_C2,
    DST_Q53,
    DST_CDIS,
    DST_A53,
    DST_P,
    DST_PADD,
    DST_D,
    DST_QINIT,
    DST_QUPD,
    DST_RES_ZERO,
    DST_RES_KEEP,
    DST_RES_SPLIT
  } dst_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_go;
    mul_sel_t  mul_sel;
    logic      div_go;
    div_sel_t  div_sel;
    logic      cbrt_go;
    cbrt_sel_t cbrt_sel;
    dst_t      wr;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic cbrt_done;
    logic f_zero;
    logic dx_zero;
    logic q_pos;
    logic it_below;
    logic d_zero;
    logic stop;
  } stat_t;

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, VMAX}) ? VMAX : s[63:0];
  endfunction

  function automatic logic [63:0] mul24_sat(input logic [127:0] p);
    logic [63:0] r;
    r = p[87:24];
    if (p[127:88] != '0) return VMAX;
    return (r > VMAX) ? VMAX : r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/kwcs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_mul
// 64 x 64 multiplier built from four 32 x 32 partial products over cycles.
// ----------------------------------------------------------------------------
module kwcs_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      prod
);

  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   ph_r, ph_nxt;
  logic         run_r, run_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh;

  assign a_part = ph_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = ph_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (ph_r) inside
      3'd1:       pp_sh = {64'b0, pp_r};
      3'd2, 3'd3: pp_sh = {32'b0, pp_r, 32'b0};
      3'd4:       pp_sh = {pp_r, 64'b0};
      default:    pp_sh = '0;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
      ph_nxt  = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      pp_nxt  = {32'b0, a_part} * {32'b0, b_part};
      acc_nxt = acc_r + pp_sh;
      ph_nxt  = ph_r + 3'd1;
      if (ph_r == 3'd4) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
    ph_r  <= ph_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

FILE: hw/rtl/kwcs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_div
// Restoring 128 / 64 divider, one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
module kwcs_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [127:0] numer,
  input  wire logic [63:0]  denom,
  output logic              done,
  output logic [63:0]       quot
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        sat_r, sat_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [63:0] rs;
  logic        ge;

  assign rs = {rem_r[62:0], lo_r[63]};
  assign ge = rem_r[63] || (rs >= d_r);

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      d_nxt   = denom;
      rem_nxt = numer[127:64];
      lo_nxt  = numer[63:0];
      quo_nxt = '0;
      cnt_nxt = 7'(kwcs_pkg::DIV_STEPS);
      if (numer[127:64] >= denom) begin
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        sat_nxt = 1'b0;
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      rem_nxt = ge ? (rs - d_r) : rs;
      lo_nxt  = {lo_r[62:0], 1'b0};
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = (sat_r || (quo_r > kwcs_pkg::VMAX)) ? kwcs_pkg::VMAX : quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/kwcs_cbrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_cbrt
// Q.24 cube root: normalize by 3-bit steps, then 22 digit steps of an
// integer cube root, then scale back.
// ----------------------------------------------------------------------------
module kwcs_cbrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [63:0]      root
);

  logic [65:0] xs_r, xs_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [21:0] y_r, y_nxt;
  logic [51:0] r_r, r_nxt;
  logic        norm_r, norm_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [21:0] y2;
  logic [44:0] pr;
  logic [51:0] bv;
  logic [51:0] rr;
  logic [37:0] ys;

  assign y2 = {y_r[20:0], 1'b0};
  assign pr = {23'b0, y2} * ({23'b0, y2} + 45'd1);
  assign bv = ({7'b0, pr} << 1) + {7'b0, pr} + 52'd1;
  assign rr = {r_r[48:0], xs_r[65:63]};
  assign ys = {16'b0, y_r} << k_r;

  always_comb begin
    xs_nxt   = xs_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    y_nxt    = y_r;
    r_nxt    = r_r;
    norm_nxt = norm_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      xs_nxt   = {2'b0, x};
      k_nxt    = 5'(kwcs_pkg::NORM_MAX);
      norm_nxt = 1'b1;
      run_nxt  = 1'b1;
    end else if (run_r && norm_r) begin
      if ((k_r != 5'd0) && (xs_r[63:61] == 3'b000)) begin
        xs_nxt = {2'b0, xs_r[60:0], 3'b0};
        k_nxt  = k_r - 5'd1;
      end else begin
        norm_nxt = 1'b0;
        cnt_nxt  = 5'(kwcs_pkg::ROOT_STEPS);
        y_nxt    = '0;
        r_nxt    = '0;
      end
    end else if (run_r) begin
      xs_nxt = {xs_r[62:0], 3'b0};
      if (rr >= bv) begin
        r_nxt = rr - bv;
        y_nxt = y2 + 22'd1;
      end else begin
        r_nxt = rr;
        y_nxt = y2;
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    y_r    <= y_nxt;
    r_r    <= r_nxt;
    norm_r <= norm_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = {26'b0, ys};

endmodule
`default_nettype wire

FILE: hw/rtl/kwcs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_dp
// Solver datapath: operand registers, shared multiplier, divider and cube
// root, Newton update and result register.
// ----------------------------------------------------------------------------
module kwcs_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kwcs_pkg::in_item_t  in_item,
  input  wire kwcs_pkg::cmd_t      cmd,
  input  wire logic [31:0]         dt_secs,
  input  wire logic [7:0]          iteration_limit,
  input  wire logic [31:0]         step_tolerance,
  output kwcs_pkg::stat_t          stat,
  output logic                     out_valid,
  output kwcs_pkg::out_item_t      out_item
);

  logic [kwcs_pkg::CELL_INDEX_BITS-1:0] tag_r;
  logic [31:0] f_r, qup_r, alpha_r, dx_r;
  logic [63:0] cdis_r, a53_r, c2_r, q53_r, p_r, d_r, q_r;
  logic [7:0]  it_r;
  logic        out_valid_r;
  kwcs_pkg::out_item_t out_r;

  logic [63:0]  dt24, a24, mag, step_val, qsum, df, qstart;
  logic         pos;
  logic [63:0]  mul_a, mul_b, cb_x, div_d, cb_root, div_q, m24;
  logic [127:0] div_n, mul_p;
  logic         mul_done, div_done, cb_done;

  assign dt24 = {24'b0, dt_secs, 8'b0};
  assign a24  = {24'b0, alpha_r, 8'b0};
  assign pos  = p_r >= cdis_r;
  assign mag  = pos ? (p_r - cdis_r) : (cdis_r - p_r);
  assign m24  = kwcs_pkg::mul24_sat(mul_p);
  assign step_val = (d_r == '0) ? '0 : div_q;
  assign qsum = q_r + step_val;
  assign df   = div_q;
  assign qstart = kwcs_pkg::add_sat(cdis_r, {32'b0, qup_r});

  always_comb begin
    unique case (cmd.mul_sel)
      kwcs_pkg::MS_CC:    begin mul_a = cb_root; mul_b = cb_root;               end
      kwcs_pkg::MS_FC2:   begin mul_a = {32'b0, f_r}; mul_b = c2_r;             end
      kwcs_pkg::MS_AQ53:  begin mul_a = a24; mul_b = q53_r;                     end
      kwcs_pkg::MS_AK:    begin mul_a = a24; mul_b = kwcs_pkg::FIVE_THIRDS;     end
      kwcs_pkg::MS_QC2:   begin mul_a = q_r; mul_b = c2_r;                      end
      kwcs_pkg::MS_DTQ:   begin mul_a = dt24; mul_b = q_r;                      end
      kwcs_pkg::MS_A53C2: begin mul_a = a53_r; mul_b = c2_r;                    end
      kwcs_pkg::MS_QDT:   begin mul_a = q_r; mul_b = {32'b0, dt_secs};          end
      default:            begin mul_a = '0; mul_b = '0;                         end
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      kwcs_pkg::DS_STEP:  begin div_n = {40'b0, mag, 24'b0}; div_d = d_r;      end
      kwcs_pkg::DS_ROUTE: begin div_n = mul_p; div_d = {32'b0, dx_r};          end
      default:            begin div_n = '0; div_d = '0;                        end
    endcase
  end

  assign cb_x = (cmd.cbrt_sel == kwcs_pkg::CS_Q) ? q_r : {32'b0, f_r};

  kwcs_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  kwcs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .numer(div_n),
    .denom(div_d),
    .done (div_done),
    .quot (div_q)
  );

  kwcs_cbrt u_cbrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.cbrt_go),
    .x    (cb_x),
    .done (cb_done),
    .root (cb_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tag_r   <= in_item.cell_index;
      f_r     <= in_item.flow_depth;
      qup_r   <= in_item.upslope_discharge;
      alpha_r <= in_item.manning_alpha;
      dx_r    <= in_item.flow_length;
      it_r    <= '0;
    end
    unique case (cmd.wr)
      kwcs_pkg::DST_NONE:  ;
      kwcs_pkg::DST_C2:    c2_r   <= m24;
      kwcs_pkg::DST_Q53:   q53_r  <= m24;
      kwcs_pkg::DST_CDIS:  cdis_r <= m24;
      kwcs_pkg::DST_A53:   a53_r  <= m24;
      kwcs_pkg::DST_P:     p_r    <= m24;
      kwcs_pkg::DST_PADD:  p_r    <= kwcs_pkg::add_sat(p_r, m24);
      kwcs_pkg::DST_D:     d_r    <= kwcs_pkg::add_sat(dt24, m24);
      kwcs_pkg::DST_QINIT: q_r    <= {1'b0, qstart[63:1]};
      kwcs_pkg::DST_QUPD: begin
        it_r <= it_r + 8'd1;
        if (pos) q_r <= q_r - step_val;
        else     q_r <= (qsum > kwcs_pkg::VMAX) ? kwcs_pkg::VMAX : qsum;
      end
      kwcs_pkg::DST_RES_ZERO: begin
        out_r.cell_tag        <= tag_r;
        out_r.kept_depth      <= '0;
        out_r.routed_depth    <= '0;
        out_r.iterations_used <= it_r;
      end
      kwcs_pkg::DST_RES_KEEP: begin
        out_r.cell_tag        <= tag_r;
        out_r.kept_depth      <= f_r;
        out_r.routed_depth    <= '0;
        out_r.iterations_used <= it_r;
      end
      kwcs_pkg::DST_RES_SPLIT: begin
        out_r.cell_tag        <= tag_r;
        out_r.iterations_used <= it_r;
        if ({32'b0, f_r} > df) begin
          out_r.kept_depth   <= f_r - df[31:0];
          out_r.routed_depth <= df[31:0];
        end else begin
          out_r.kept_depth   <= '0;
          out_r.routed_depth <= f_r;
        end
      end
      default: ;
    endcase
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.wr == kwcs_pkg::DST_RES_ZERO) ||
                     (cmd.wr == kwcs_pkg::DST_RES_KEEP) ||
                     (cmd.wr == kwcs_pkg::DST_RES_SPLIT);
    end
  end

  always_comb begin
    stat.mul_done  = mul_done;
    stat.div_done  = div_done;
    stat.cbrt_done = cb_done;
    stat.f_zero    = (f_r == '0);
    stat.dx_zero   = (dx_r == '0);
    stat.q_pos     = !q_r[63] && (q_r != '0);
    stat.it_below  = it_r < iteration_limit;
    stat.d_zero    = (d_r == '0);
    stat.stop      = step_val < {32'b0, step_tolerance};
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

FILE: hw/rtl/kwcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwcs_ctrl
// Solver sequencer: walks set-up, Newton iterations and routing, issuing one
// arithmetic operation at a time to the datapath.
// ----------------------------------------------------------------------------
module kwcs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire kwcs_pkg::stat_t stat,
  output kwcs_pkg::cmd_t       cmd,
  output logic                 busy
);

  kwcs_pkg::state_t state_r, state_nxt;
  logic             issued_r, issued_nxt;

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = 1'b0;
    unique case (state_r)
      kwcs_pkg::S_IDLE:     if (start) state_nxt = kwcs_pkg::S_CHECK;
      kwcs_pkg::S_CHECK:    state_nxt = (stat.f_zero || stat.dx_zero) ?
                                        kwcs_pkg::S_IDLE : kwcs_pkg::S_PF_CBRT;
      kwcs_pkg::S_PF_CBRT: begin
        issued_nxt = !stat.cbrt_done;
        if (stat.cbrt_done) state_nxt = kwcs_pkg::S_PF_C2;
      end
      kwcs_pkg::S_PF_C2: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_PF_Q53;
      end
      kwcs_pkg::S_PF_Q53: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_CDIS;
      end
      kwcs_pkg::S_CDIS: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_A53;
      end
      kwcs_pkg::S_A53: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_QINIT;
      end
      kwcs_pkg::S_QINIT:    state_nxt = kwcs_pkg::S_LOOP;
      kwcs_pkg::S_LOOP:     state_nxt = (stat.q_pos && stat.it_below) ?
                                        kwcs_pkg::S_IT_CBRT : kwcs_pkg::S_POST;
      kwcs_pkg::S_IT_CBRT: begin
        issued_nxt = !stat.cbrt_done;
        if (stat.cbrt_done) state_nxt = kwcs_pkg::S_IT_C2;
      end
      kwcs_pkg::S_IT_C2: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_IT_Q53;
      end
      kwcs_pkg::S_IT_Q53: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_IT_M1;
      end
      kwcs_pkg::S_IT_M1: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_IT_M2;
      end
      kwcs_pkg::S_IT_M2: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_IT_M3;
      end
      kwcs_pkg::S_IT_M3: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_IT_DIV;
      end
      kwcs_pkg::S_IT_DIV: begin
        if (stat.d_zero) begin
          state_nxt = kwcs_pkg::S_IT_UPD;
        end else begin
          issued_nxt = !stat.div_done;
          if (stat.div_done) state_nxt = kwcs_pkg::S_IT_UPD;
        end
      end
      kwcs_pkg::S_IT_UPD:   state_nxt = stat.stop ? kwcs_pkg::S_POST : kwcs_pkg::S_LOOP;
      kwcs_pkg::S_POST:     state_nxt = stat.q_pos ? kwcs_pkg::S_POST_MUL : kwcs_pkg::S_IDLE;
      kwcs_pkg::S_POST_MUL: begin
        issued_nxt = !stat.mul_done;
        if (stat.mul_done) state_nxt = kwcs_pkg::S_POST_DIV;
      end
      kwcs_pkg::S_POST_DIV: begin
        issued_nxt = !stat.div_done;
        if (stat.div_done) state_nxt = kwcs_pkg::S_IDLE;
      end
      default:              state_nxt = kwcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      kwcs_pkg::S_IDLE:     cmd.load_in = start;
      kwcs_pkg::S_CHECK: begin
        if (stat.f_zero)       cmd.wr = kwcs_pkg::DST_RES_ZERO;
        else if (stat.dx_zero) cmd.wr = kwcs_pkg::DST_RES_KEEP;
      end
      kwcs_pkg::S_PF_CBRT: begin
        cmd.cbrt_go  = !issued_r;
        cmd.cbrt_sel = kwcs_pkg::CS_F;
      end
      kwcs_pkg::S_PF_C2: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_CC;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_C2;
      end
      kwcs_pkg::S_PF_Q53: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_FC2;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_Q53;
      end
      kwcs_pkg::S_CDIS: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_AQ53;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_CDIS;
      end
      kwcs_pkg::S_A53: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_AK;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_A53;
      end
      kwcs_pkg::S_QINIT:    cmd.wr = kwcs_pkg::DST_QINIT;
      kwcs_pkg::S_LOOP:     ;
      kwcs_pkg::S_IT_CBRT: begin
        cmd.cbrt_go  = !issued_r;
        cmd.cbrt_sel = kwcs_pkg::CS_Q;
      end
      kwcs_pkg::S_IT_C2: begin
        cmd.mul_go   = !issued_r;
        cmd.mul_sel  = kwcs_pkg::MS_CC;
        cmd.cbrt_sel = kwcs_pkg::CS_Q;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_C2;
      end
      kwcs_pkg::S_IT_Q53: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_QC2;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_Q53;
      end
      kwcs_pkg::S_IT_M1: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_DTQ;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_P;
      end
      kwcs_pkg::S_IT_M2: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_AQ53;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_PADD;
      end
      kwcs_pkg::S_IT_M3: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_A53C2;
        if (stat.mul_done) cmd.wr = kwcs_pkg::DST_D;
      end
      kwcs_pkg::S_IT_DIV: begin
        cmd.div_go  = !issued_r && !stat.d_zero;
        cmd.div_sel = kwcs_pkg::DS_STEP;
      end
      kwcs_pkg::S_IT_UPD:   cmd.wr = kwcs_pkg::DST_QUPD;
      kwcs_pkg::S_POST:     if (!stat.q_pos) cmd.wr = kwcs_pkg::DST_RES_KEEP;
      kwcs_pkg::S_POST_MUL: begin
        cmd.mul_go  = !issued_r;
        cmd.mul_sel = kwcs_pkg::MS_QDT;
      end
      kwcs_pkg::S_POST_DIV: begin
        cmd.div_go  = !issued_r;
        cmd.div_sel = kwcs_pkg::DS_ROUTE;
        if (stat.div_done) cmd.wr = kwcs_pkg::DST_RES_SPLIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= kwcs_pkg::S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  assign busy = (state_r != kwcs_pkg::S_IDLE);

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_go, cmd.div_go, cmd.cbrt_go}))
    else $error("more than one arithmetic unit started");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kwcs_pkg::S_IDLE && start) |=> (state_r == kwcs_pkg::S_CHECK))
    else $error("accepted item did not start");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.mul_done || stat.div_done || stat.cbrt_done) |-> busy)
    else $error("unit finished while idle");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr == kwcs_pkg::DST_RES_ZERO || cmd.wr == kwcs_pkg::DST_RES_KEEP ||
     cmd.wr == kwcs_pkg::DST_RES_SPLIT) |=> (state_r == kwcs_pkg::S_IDLE))
    else $error("result written without returning to idle");

endmodule
`default_nettype wire

FILE: hw/rtl/kinematic_wave_cell_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kinematic_wave_cell_solver
// Per-cell kinematic wave routing by Newton-Raphson on Manning discharge.
//
// Raise start with an item on in_item; it is taken when busy is low. busy
// stays high until the result is written; out_valid then pulses for one
// cycle with out_item, and a new item may be started in that same cycle.
// The result cannot be held off by the receiver.
// Items of zero depth or on a sink are answered at the check state, with no
// Newton iteration. Each Newton iteration runs one shared cube root (0 to 16
// normalize shifts), five passes of the four partial product multiplier and
// the divider, which is skipped when the step denominator is zero. One item
// is in flight at a time. cfg_we writes register cfg_index (0 time step,
// 1 iteration limit, 2 step tolerance) from cfg_wdata; index 3 is ignored.
// Write only while the block is idle; the block itself does not enforce
// this. Reset (rst_n low, synchronous) returns the registers to their
// defaults, idles the sequencer and drops out_valid.
// ----------------------------------------------------------------------------
module kinematic_wave_cell_solver (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire kwcs_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output kwcs_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  logic [31:0] dt_secs_r;
  logic [7:0]  iteration_limit_r;
  logic [31:0] step_tolerance_r;
  kwcs_pkg::cmd_t  cmd;
  kwcs_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_secs_r         <= kwcs_pkg::DT_SECS_RST;
      iteration_limit_r <= kwcs_pkg::ITER_LIMIT_RST;
      step_tolerance_r  <= kwcs_pkg::STEP_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kwcs_pkg::REG_DT_SECS:    dt_secs_r         <= cfg_wdata;
        kwcs_pkg::REG_ITER_LIMIT: iteration_limit_r <= cfg_wdata[7:0];
        kwcs_pkg::REG_STEP_TOL:   step_tolerance_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kwcs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  kwcs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .cmd            (cmd),
    .dt_secs        (dt_secs_r),
    .iteration_limit(iteration_limit_r),
    .step_tolerance (step_tolerance_r),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_item       (out_item)
  );

endmodule
`default_nettype wire
